// File: src/rgbcp_pkg.sv
// Shared types, constants and byte class codes for the RGB command parser.
package rgbcp_pkg;

	// Message length limit, '!' included
	localparam int unsigned MESSAGE_BYTES = 50;

	// Character codes
	localparam logic [7:0] DELIM_BYTE = 8'h3A;
	localparam logic [7:0] END_BYTE   = 8'h21;
	localparam logic [7:0] PLUS_BYTE  = 8'h2B;
	localparam logic [7:0] MINUS_BYTE = 8'h2D;
	localparam logic [7:0] ZERO_BYTE  = 8'h30;

	// Field counts
	localparam int unsigned NUM_FIELDS = 4;
	localparam int unsigned FIELD_IDX_W = $clog2(NUM_FIELDS);
	localparam int unsigned FIELD_CNT_W = $clog2(NUM_FIELDS + 1);

	// Queue between classifier and parser
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Output beat layout
	localparam int unsigned OUT_BITS = 4 * 8 + FIELD_CNT_W + 1;
	localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Byte classes
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_OTHER = 3'd0;
	localparam kind_t KIND_BLANK = 3'd1;
	localparam kind_t KIND_PLUS  = 3'd2;
	localparam kind_t KIND_MINUS = 3'd3;
	localparam kind_t KIND_DIGIT = 3'd4;
	localparam kind_t KIND_DELIM = 3'd5;
	localparam kind_t KIND_END   = 3'd6;

	// Number phase codes
	localparam logic [1:0] PH_LEAD = 2'd0;
	localparam logic [1:0] PH_NUM  = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	// One classified byte
	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
	} item_t;

endpackage

// File: src/rgbcp_front.sv
// Byte classifier: sorts each received byte into a class and a digit value.
module rgbcp_front (
	input  logic [7:0]     rx_byte,
	output rgbcp_pkg::item_t item
);
	import rgbcp_pkg::*;

	logic [7:0] digit_full;

	assign digit_full = rx_byte - ZERO_BYTE;

	// Classify the byte
	always_comb begin
		item.digit = digit_full[3:0];
		case (rx_byte) inside
			END_BYTE:             item.kind = KIND_END;
			DELIM_BYTE:           item.kind = KIND_DELIM;
			PLUS_BYTE:            item.kind = KIND_PLUS;
			MINUS_BYTE:           item.kind = KIND_MINUS;
			[8'h30:8'h39]:        item.kind = KIND_DIGIT;
			[8'h09:8'h0D], 8'h20: item.kind = KIND_BLANK;
			default:              item.kind = KIND_OTHER;
		endcase
	end

endmodule

// File: src/rgbcp_queue.sv
// Short flop queue that decouples the classifier from the parser.
module rgbcp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rgbcp_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output rgbcp_pkg::item_t head_item
);
	import rgbcp_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push without pop did not grow queue");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop without push did not shrink queue");
`endif

endmodule

// File: src/rgbcp_back.sv
// Parser: runs the field accumulator on classified bytes and emits results.
module rgbcp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  rgbcp_pkg::item_t                    head_item,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rgbcp_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import rgbcp_pkg::*;

	logic [7:0]             field_q [NUM_FIELDS];
	logic [FIELD_CNT_W-1:0] field_count_q;
	logic [7:0]             running_q;
	logic [1:0]             phase_q;
	logic                   minus_q;
	logic [7:0]             byte_count_q;
	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    out_data_q;
	logic [7:0]             times_ten;
	logic [7:0]             signed_value;
	logic                   is_end;
	logic                   fields_room;

	assign is_end       = (head_item.kind == KIND_END);
	assign pop          = head_valid && (!is_end || !out_valid_q || m_tready);
	assign times_ten    = (running_q << 3) + (running_q << 1) + {4'd0, head_item.digit};
	assign signed_value = minus_q ? (8'd0 - running_q) : running_q;
	assign fields_room  = (field_count_q < FIELD_CNT_W'(NUM_FIELDS));
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_data_q};

	// Capture the result beat on the terminator
	always_ff @(posedge clk) begin
		if (pop && is_end) begin
			out_data_q <= {(byte_count_q >= 8'(MESSAGE_BYTES)), field_count_q,
				field_q[3], field_q[2], field_q[1], field_q[0]};
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Update parser state per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				field_q[i] <= '0;
			end
			field_count_q <= '0;
			running_q     <= '0;
			phase_q       <= PH_LEAD;
			minus_q       <= 1'b0;
			byte_count_q  <= '0;
		end else if (pop) begin
			if (is_end) begin
				for (int i = 0; i < NUM_FIELDS; i++) begin
					field_q[i] <= '0;
				end
				field_count_q <= '0;
				running_q     <= '0;
				phase_q       <= PH_LEAD;
				minus_q       <= 1'b0;
				byte_count_q  <= '0;
			end else begin
				if (byte_count_q != 8'hFF) begin
					byte_count_q <= byte_count_q + 1'b1;
				end
				if (head_item.kind == KIND_DELIM) begin
					// Close the field; drop extra fields
					if (fields_room) begin
						field_q[field_count_q[FIELD_IDX_W-1:0]] <= signed_value;
						field_count_q <= field_count_q + 1'b1;
					end
					running_q <= '0;
					phase_q   <= PH_LEAD;
					minus_q   <= 1'b0;
				end else if (phase_q == PH_LEAD) begin
					case (head_item.kind)
						KIND_BLANK: ;
						KIND_PLUS: begin
							minus_q <= 1'b0;
							phase_q <= PH_NUM;
						end
						KIND_MINUS: begin
							minus_q <= 1'b1;
							phase_q <= PH_NUM;
						end
						KIND_DIGIT: begin
							running_q <= {4'd0, head_item.digit};
							phase_q   <= PH_NUM;
						end
						default: phase_q <= PH_DONE;
					endcase
				end else if (phase_q == PH_NUM) begin
					if (head_item.kind == KIND_DIGIT) begin
						running_q <= times_ten;
					end else begin
						phase_q <= PH_DONE;
					end
				end
			end
		end
	end

endmodule

// File: src/colon_delimited_rgb_command_parser_core.sv
// A '!' beat passes the queue, then the output beat register, before it shows on m_tvalid.
// Throughput: one byte per cycle while s_tready is high, with the parser's combinational
// multiply-by-ten accumulate. A four-entry queue between classifier and parser absorbs output
// stalls; s_tready drops only when it fills while a result waits. Reset (arst_n low) clears
// the queue, all parser state and m_tvalid at once; no clearing pass is needed.
module colon_delimited_rgb_command_parser_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // [7:0] rx_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] red_level, [15:8] green_level, [23:16] blue_level,
	// [31:24] brightness_level, [34:32] fields_closed, [35] length_overflow
	output logic [rgbcp_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rgbcp_pkg::*;

	item_t class_item;
	item_t head_item;
	logic  queue_full;
	logic  head_valid;
	logic  pop;

	assign s_tready = !queue_full;

	// Classify incoming beats
	rgbcp_front u_front (
		.rx_byte (s_tdata),
		.item    (class_item)
	);

	// Buffer classified bytes
	rgbcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_tvalid),
		.push_item  (class_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Parse and emit results
	rgbcp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
